// ===== sv/rbp_pkg.sv =====
// Shared types and constants for the relay bank PWM / timed-off unit.
`default_nettype none

package rbp_pkg;

  // Input command modes
  localparam logic [2:0] MODE_ON    = 3'd0;
  localparam logic [2:0] MODE_OFF   = 3'd1;
  localparam logic [2:0] MODE_PWM   = 3'd2;
  localparam logic [2:0] MODE_DELAY = 3'd3;
  localparam logic [2:0] MODE_PTICK = 3'd4;
  localparam logic [2:0] MODE_STICK = 3'd5;
  localparam logic [2:0] MODE_QUERY = 3'd6;

  // Relay mode codes
  localparam logic [15:0] CODE_OFF       = 16'd0;
  localparam logic [15:0] CODE_ON        = 16'd1;
  localparam logic [15:0] CODE_PWM_BASE  = 16'd10;
  localparam logic [15:0] CODE_PWM_LO    = 16'd11;
  localparam logic [15:0] CODE_PWM_HI    = 16'd19;
  localparam logic [15:0] CODE_DLY_BASE  = 16'd19;
  localparam logic [15:0] CODE_DLY_MIN   = 16'd20;

  localparam logic [15:0] DELAY_MAX      = 16'd36000;
  localparam logic [6:0]  PCT_MIN        = 7'd10;
  localparam logic [6:0]  PCT_MAX        = 7'd99;
  localparam logic [3:0]  PHASE_LAST     = 4'd9;
  // percent / 10 == (percent * 205) >> 11 for all 7-bit values
  localparam logic [14:0] DIV10_MUL      = 15'd205;
  localparam int          DIV10_SHIFT    = 11;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  relay;
    logic [6:0]  percent;
    logic [15:0] delay_tenths;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pin_levels;
    logic       relay_on;
    logic       relay_delayed;
    logic       accepted;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_READ  = 2'd1,
    OP_PTICK = 2'd2,
    OP_STICK = 2'd3
  } op_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t         op;
    logic        ok;      // relay number in range
    logic        acc;     // accepted flag for the result
    logic        wr_on;   // update logical level
    logic        on_val;
    logic [3:0]  idx;     // relay number minus one
    logic [15:0] code;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/rbp_front.sv =====
// Front end: accept input items and classify them into commands.
`default_nettype none

module rbp_front import rbp_pkg::*; #(
  parameter int RELAY_COUNT = 8
) (
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_data
);

  logic        ok;
  logic [14:0] prod;
  logic [3:0]  duty;
  logic        pwm_ok;
  logic        dly_ok;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign ok     = (in_data.relay != 4'd0) && (in_data.relay <= 4'(RELAY_COUNT));
  assign prod   = 15'(in_data.percent) * DIV10_MUL;
  assign duty   = prod[DIV10_SHIFT+3:DIV10_SHIFT];
  assign pwm_ok = (in_data.percent >= PCT_MIN) && (in_data.percent <= PCT_MAX);
  assign dly_ok = (in_data.delay_tenths != 16'd0) && (in_data.delay_tenths <= DELAY_MAX);

  always_comb begin
    q_data        = '0;
    q_data.op     = OP_READ;
    q_data.ok     = ok;
    q_data.idx    = ok ? in_data.relay - 4'd1 : 4'd0;
    case (in_data.mode)
      MODE_ON: begin
        q_data.acc = ok;
        if (ok) begin
          q_data.op     = OP_SET;
          q_data.code   = CODE_ON;
          q_data.wr_on  = 1'b1;
          q_data.on_val = 1'b1;
        end
      end
      MODE_OFF: begin
        q_data.acc = ok;
        if (ok) begin
          q_data.op     = OP_SET;
          q_data.code   = CODE_OFF;
          q_data.wr_on  = 1'b1;
          q_data.on_val = 1'b0;
        end
      end
      MODE_PWM: begin
        q_data.acc = ok && pwm_ok;
        if (ok && pwm_ok) begin
          q_data.op   = OP_SET;
          q_data.code = CODE_PWM_BASE + 16'(duty);
        end
      end
      MODE_DELAY: begin
        q_data.acc = ok && dly_ok;
        if (ok && dly_ok) begin
          q_data.op     = OP_SET;
          q_data.code   = CODE_DLY_BASE + in_data.delay_tenths;
          q_data.wr_on  = 1'b1;
          q_data.on_val = 1'b1;
        end
      end
      MODE_PTICK: begin
        q_data.op  = OP_PTICK;
        q_data.acc = 1'b1;
      end
      MODE_STICK: begin
        q_data.op  = OP_STICK;
        q_data.acc = 1'b1;
      end
      MODE_QUERY: begin
        q_data.acc = ok;
      end
      default: begin
        q_data.acc = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/rbp_queue.sv =====
// Two-entry command queue between front and back.
`default_nettype none

module rbp_queue import rbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rbp_back.sv =====
// Back end: relay state, mode code memory, tick walks and the result register.
`default_nettype none

module rbp_back import rbp_pkg::*; #(
  parameter int RELAY_COUNT = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       q_empty,
  input  wire cmd_t       q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  localparam int IDX_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(RELAY_COUNT - 1);
  localparam logic [7:0] PIN_MASK =
    (RELAY_COUNT >= 8) ? 8'hFF : 8'((1 << RELAY_COUNT) - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                 state;
  cmd_t                   cmd;
  logic [IDX_W-1:0]       walk;
  logic [3:0]             phase;
  logic [7:0]             mask;
  logic [RELAY_COUNT-1:0] lon;
  logic [RELAY_COUNT-1:0] vld;
  logic [15:0]            mem [RELAY_COUNT];
  logic [15:0]            rd_data;
  logic [IDX_W-1:0]       rd_idx;
  logic                   res_on;
  logic                   res_del;

  logic [IDX_W-1:0]       head_idx;
  logic [IDX_W-1:0]       rd_addr;
  logic [15:0]            code;
  logic [15:0]            nc;
  logic                   stick_wr;
  logic                   is_pwm;
  logic                   duty_hit;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [15:0]            mem_wd;
  logic [15:0]            lon_ext;
  logic                   out_free;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign head_idx = q_data.idx[IDX_W-1:0];
  // never-written entries read as off
  assign code     = vld[rd_idx] ? rd_data : CODE_OFF;
  assign is_pwm   = (code >= CODE_PWM_LO) && (code <= CODE_PWM_HI);
  assign duty_hit = (code[4:0] - CODE_PWM_BASE[4:0]) == {1'b0, phase};
  assign stick_wr = (cmd.op == OP_STICK) && (code >= CODE_DLY_MIN);
  assign lon_ext  = 16'(lon);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    nc = code;
    if (stick_wr) begin
      nc = (code == CODE_DLY_MIN) ? CODE_OFF : code - 16'd1;
    end
  end

  always_comb begin
    rd_addr = '0;
    case (state)
      // ticks start their walk at the first relay
      S_IDLE: rd_addr = (q_data.op == OP_PTICK || q_data.op == OP_STICK) ? '0 : head_idx;
      S_WALK: rd_addr = (walk == LAST) ? walk : walk + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = walk;
    mem_wd = nc;
    if (state == S_IDLE) begin
      mem_we = q_pop && (q_data.op == OP_SET);
      mem_wa = head_idx;
      mem_wd = q_data.code;
    end else if (state == S_WALK) begin
      mem_we = stick_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      mask      <= 8'hFF;
      lon       <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask <= cfg_wr_data;
      end
      if (mem_we) begin
        vld[mem_wa] <= 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd     <= q_data;
            res_on  <= 1'b0;
            res_del <= 1'b0;
            walk    <= '0;
            case (q_data.op)
              OP_SET: begin
                if (q_data.wr_on) begin
                  lon[head_idx] <= q_data.on_val;
                end
                res_on  <= q_data.code != CODE_OFF;
                res_del <= q_data.code > CODE_PWM_HI;
                state   <= S_FIN;
              end
              OP_READ: state <= S_READ;
              OP_PTICK: begin
                phase <= (phase == PHASE_LAST) ? 4'd0 : phase + 4'd1;
                state <= S_WALK;
              end
              OP_STICK: state <= S_WALK;
              default: state <= S_FIN;
            endcase
          end
        end
        S_READ: begin
          res_on  <= cmd.ok && (code != CODE_OFF);
          res_del <= cmd.ok && (code > CODE_PWM_HI);
          state   <= S_FIN;
        end
        S_WALK: begin
          if (cmd.op == OP_PTICK && is_pwm) begin
            if (phase == 4'd0) begin
              lon[walk] <= 1'b1;
            end else if (duty_hit) begin
              lon[walk] <= 1'b0;
            end
          end
          if (stick_wr && nc == CODE_OFF) begin
            lon[walk] <= 1'b0;
          end
          // capture the addressed relay's code after this step
          if (cmd.ok && cmd.idx[IDX_W-1:0] == walk) begin
            res_on  <= nc != CODE_OFF;
            res_del <= nc > CODE_PWM_HI;
          end
          if (walk == LAST) begin
            state <= S_FIN;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.pin_levels    <= ~(mask ^ lon_ext[7:0]) & PIN_MASK;
            out_data.relay_on      <= res_on;
            out_data.relay_delayed <= res_del;
            out_data.accepted      <= cmd.acc;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/relay_bank_pwm_timed_off_unit.sv =====
// The back end runs one item at a time and waits on the output stall before it
// registers a result. A tick walks the mode code memory one entry per cycle, and a
// two-entry queue buffers input.
// Reset: all relays off, PWM phase 0, polarity mask all ones; no clearing pass.
`default_nettype none

module relay_bank_pwm_timed_off_unit import rbp_pkg::*; #(
  parameter int RELAY_COUNT = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  rbp_front #(.RELAY_COUNT(RELAY_COUNT)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_cmd)
  );

  rbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  rbp_back #(.RELAY_COUNT(RELAY_COUNT)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_data      (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/rbp_checker.sv =====
// Port-level assertions for the relay bank unit and their bind.
`default_nettype none

module rbp_checker import rbp_pkg::*; #(
  parameter int RELAY_COUNT = 8
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire out_item_t  out_data
);

  localparam logic [7:0] PIN_MASK =
    (RELAY_COUNT >= 8) ? 8'hFF : 8'((1 << RELAY_COUNT) - 1);

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  a_pin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.pin_levels & ~PIN_MASK) == 8'd0))
    else $error("pin bit set beyond relay count");

  a_delay_on: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.relay_delayed || out_data.relay_on))
    else $error("countdown reported on a relay that is off");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind relay_bank_pwm_timed_off_unit rbp_checker #(.RELAY_COUNT(RELAY_COUNT)) u_rbp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
